// ===== rtl/dctd_pkg.sv =====
`timescale 1ns / 1ps
package dctd_pkg;

    localparam int SLOT_W    = 4;
    localparam int ELAPSED_W = 8;
    localparam int DELAY_W   = 16;
    localparam int DIV_W     = 16;
    localparam int COUNT_W   = 5;
    localparam int ACC_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT  = 1'd1;

    localparam logic MODE_PASS = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    // microprogram addresses
    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_LOAD,
        S_CMP,
        S_PRIME,
        S_DEC,
        S_CHKRD,
        S_CHK
    } t_step;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_ACC,
        OP_LOAD,
        OP_CMP,
        OP_PRIME,
        OP_DEC,
        OP_CHKRD,
        OP_CHK
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_MODE,
        C_TICK,
        C_MORE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  emit;
        t_step next_t;
        t_step next_f;
    } t_uword;

    // control store
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        case (step)
            S_IDLE:  w = '{OP_WAIT,  C_ACCEPT, 1'b0, S_ACC,   S_IDLE};
            S_ACC:   w = '{OP_ACC,   C_MODE,   1'b0, S_LOAD,  S_CMP};
            S_LOAD:  w = '{OP_LOAD,  C_ALWAYS, 1'b1, S_IDLE,  S_IDLE};
            S_CMP:   w = '{OP_CMP,   C_TICK,   1'b0, S_PRIME, S_CHKRD};
            S_PRIME: w = '{OP_PRIME, C_ALWAYS, 1'b0, S_DEC,   S_DEC};
            S_DEC:   w = '{OP_DEC,   C_MORE,   1'b0, S_DEC,   S_CHKRD};
            S_CHKRD: w = '{OP_CHKRD, C_ALWAYS, 1'b0, S_CHK,   S_CHK};
            S_CHK:   w = '{OP_CHK,   C_ALWAYS, 1'b1, S_IDLE,  S_IDLE};
            default: w = '{OP_WAIT,  C_ALWAYS, 1'b0, S_IDLE,  S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/delay_counter_task_dispatcher.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake          | Payload (low bit first)
// s_*     | in  | s_tvalid/s_tready  | tuser: mode; tdata: elapsed_ticks[7:0],
//         |     |                    |   slot_select[11:8], delay_value[27:12]
// m_*     | out | m_tvalid/m_tready  | tuser: dispatched; tdata: dispatched_slot[3:0]
// i_cfg_* | in  | i_cfg_we           | index 0 tick_divide, 1 task_count
//
// A load word writes one counter slot. A pass word with a scheduler tick runs a
// decrement walk over the active task count of slots in the counter
// memory (one read and one write port, one slot per cycle).
// Reset is synchronous; counters read as pending through per-slot valid bits
// cleared at reset, so no clearing pass is needed.
// A full result register with m_tready low holds the sequencer at the step
// that produces the next result; the input side is ready only in the idle step.
module delay_counter_task_dispatcher #(
    parameter int MAX_TASKS  = 16,
    parameter int DELAY_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] elapsed_ticks, [11:8] slot_select, [27:12] delay_value, [31:28] zero
    input  logic [dctd_pkg::S_DATA_W-1:0]     s_tdata,
    // [0] mode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] dispatched_slot, [7:4] zero
    output logic [dctd_pkg::M_DATA_W-1:0]     m_tdata,
    // [0] dispatched
    output logic                              m_tuser,
    input  logic                              i_cfg_we,
    input  logic [dctd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dctd_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import dctd_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [DELAY_BITS-1:0] PENDING = '1;

    // config
    logic [DIV_W-1:0]   r_div;
    logic [COUNT_W-1:0] r_count;

    // sequencer
    t_step  r_step, n_step;
    t_uword uw;
    logic   cond_ok;
    logic   advance;

    // latched item
    logic                 r_mode;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [SLOT_W-1:0]    r_slot;
    logic [DELAY_W-1:0]   r_delay;

    // datapath
    logic [ACC_W-1:0]      r_acc;
    logic [IW-1:0]         r_scan;
    logic [CW-1:0]         r_idx;
    logic [IW-1:0]         r_pos;
    logic [CW-1:0]         n_eff;
    logic [ACC_W:0]        acc_sum;
    logic                  tick;
    logic [CW-1:0]         idx_m1;
    logic [CW-1:0]         scan_ext;
    logic [IW-1:0]         chk_pos;
    logic [CW-1:0]         pos_p1;

    // counter memory, valid bit clear means pending
    logic [DELAY_BITS-1:0] r_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0]  r_valid;
    logic [DELAY_BITS-1:0] r_rd_data;
    logic                  r_rd_valid;
    logic [DELAY_BITS-1:0] cval;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [DELAY_BITS-1:0] wr_data;
    logic                  wr_valid;

    // result register
    logic                r_out_valid;
    logic                r_out_disp;
    logic [SLOT_W-1:0]   r_out_slot;
    logic                res_disp;
    logic [SLOT_W-1:0]   res_slot;

    assign uw = ucode(r_step);

    // active slot count: zero acts as one, saturates at MAX_TASKS
    always_comb begin
        if (r_count == '0) begin
            n_eff = CW'(1);
        end else if (32'(r_count) > 32'(MAX_TASKS)) begin
            n_eff = CW'(MAX_TASKS);
        end else begin
            n_eff = CW'(r_count);
        end
    end

    assign acc_sum  = {1'b0, r_acc} + (ACC_W + 1)'(r_elapsed);
    assign tick     = r_acc >= ACC_W'(r_div);
    assign idx_m1   = r_idx - CW'(1);
    assign scan_ext = CW'(r_scan);
    assign chk_pos  = (scan_ext >= n_eff) ? '0 : r_scan;
    assign pos_p1   = CW'(r_pos) + CW'(1);
    assign cval     = r_rd_valid ? r_rd_data : PENDING;

    assign advance = !(uw.emit && r_out_valid && !m_tready);

    always_comb begin
        case (uw.cond)
            C_ALWAYS: cond_ok = 1'b1;
            C_ACCEPT: cond_ok = s_tvalid;
            C_MODE:   cond_ok = (r_mode == MODE_LOAD);
            C_TICK:   cond_ok = tick;
            C_MORE:   cond_ok = r_idx < n_eff;
            default:  cond_ok = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (!advance) begin
            n_step = r_step;
        end else if (cond_ok) begin
            n_step = uw.next_t;
        end else begin
            n_step = uw.next_f;
        end
    end

    // control decode: memory ports and result
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = PENDING;
        wr_valid = 1'b0;
        res_disp = 1'b0;
        res_slot = '0;
        case (uw.op)
            OP_LOAD: begin
                wr_en    = advance && (32'(r_slot) < 32'(MAX_TASKS));
                wr_addr  = IW'(r_slot);
                wr_data  = DELAY_BITS'(r_delay);
                wr_valid = 1'b1;
                res_slot = r_slot;
            end
            OP_PRIME: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            OP_DEC: begin
                rd_en    = r_idx < n_eff;
                rd_addr  = r_idx[IW-1:0];
                wr_en    = (cval != PENDING) && (cval != '0);
                wr_addr  = idx_m1[IW-1:0];
                wr_data  = cval - DELAY_BITS'(1);
                wr_valid = 1'b1;
            end
            OP_CHKRD: begin
                rd_en   = 1'b1;
                rd_addr = chk_pos;
            end
            OP_CHK: begin
                // dispatch: slot goes back to pending
                wr_en    = advance && (cval == '0);
                wr_addr  = r_pos;
                wr_valid = 1'b0;
                res_disp = cval == '0;
                res_slot = SLOT_W'(r_pos);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_div       <= DIV_W'(1);
            r_count     <= COUNT_W'(1);
            r_acc       <= '0;
            r_scan      <= '0;
            r_idx       <= '0;
            r_pos       <= '0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_mode      <= MODE_PASS;
            r_out_valid <= 1'b0;
            r_out_disp  <= 1'b0;
            r_out_slot  <= '0;
        end else begin
            r_step <= n_step;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TICK_DIVIDE: r_div   <= i_cfg_wdata;
                    CFG_TASK_COUNT:  r_count <= i_cfg_wdata[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (wr_en) begin
                r_valid[wr_addr] <= wr_valid;
            end
            if (rd_en) begin
                r_rd_valid <= r_valid[rd_addr];
            end

            case (uw.op)
                OP_WAIT: begin
                    if (s_tvalid) begin
                        r_mode <= s_tuser;
                    end
                end
                OP_ACC: begin
                    if (r_mode == MODE_PASS) begin
                        r_acc <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                    end
                end
                OP_CMP: begin
                    if (tick) begin
                        r_acc <= r_acc - ACC_W'(r_div);
                    end
                end
                OP_PRIME: r_idx <= CW'(1);
                OP_DEC:   r_idx <= r_idx + CW'(1);
                OP_CHKRD: r_pos <= chk_pos;
                OP_CHK: begin
                    if (advance) begin
                        if (cval == '0) begin
                            r_scan <= '0;
                        end else begin
                            r_scan <= (pos_p1 >= n_eff) ? '0 : pos_p1[IW-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase

            if (uw.emit && advance) begin
                r_out_valid <= 1'b1;
                r_out_disp  <= res_disp;
                r_out_slot  <= res_slot;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload, taken with the handshake
    always_ff @(posedge i_clk) begin
        if (uw.op == OP_WAIT && s_tvalid) begin
            r_elapsed <= s_tdata[7:0];
            r_slot    <= s_tdata[11:8];
            r_delay   <= s_tdata[27:12];
        end
    end

    assign s_tready = (r_step == S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_disp;
    assign m_tdata  = {{(M_DATA_W - SLOT_W){1'b0}}, r_out_slot};

endmodule

// ===== rtl/dctd_checker.sv =====
`timescale 1ns / 1ps
module dctd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dctd_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import dctd_pkg::*;

    // after an accept, every word passes through the accumulate step and at least one more step before ready returns
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("input ready too soon after accept");

    // results are only produced outside the idle step
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without sequencer work");

    // reset leaves an empty result register and an idle sequencer
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind delay_counter_task_dispatcher dctd_checker u_dctd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
